FILE: rtl/fifo_with_move_ahead_unit_defines.svh
// ---------------------------------------------------------------------------
// fifo_with_move_ahead_unit_defines.svh
// Assertion macros for the move-ahead queue.
// ---------------------------------------------------------------------------
`ifndef FIFO_WITH_MOVE_AHEAD_UNIT_DEFINES_SVH
`define FIFO_WITH_MOVE_AHEAD_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define FWMA_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fwma assertion failed");
// next-cycle implication
`define FWMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fwma assertion failed");
`else
`define FWMA_ASSERT(label, clk, rst, ante, cons)
`define FWMA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/fwma_pkg.sv
// ---------------------------------------------------------------------------
// fwma_pkg
// Types and constants shared by the move-ahead queue.
// ---------------------------------------------------------------------------
package fwma_pkg;

   // queue depth, a power of two
   localparam int DEPTH       = 16;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int VALUE_WIDTH = 32;

   typedef enum logic [1:0] {
      KIND_PUSH  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_JUMP  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_STALE = 2'd2,
      ERR_FULL  = 2'd3
   } err_type;

   typedef struct packed {
      kind_type                kind;
      logic [VALUE_WIDTH-1:0]  value_in;
      logic [IDX_W-1:0]        handle_in;
      logic [7:0]              distance;
   } req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0]  value_out;
      logic [IDX_W-1:0]        handle_out;
      logic [IDX_W-1:0]        position_out;
      logic [CNT_W-1:0]        fill_count;
      err_type                 error_code;
   } rsp_type;

   // result of the free-handle search
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] handle;
   } free_type;

endpackage

FILE: rtl/fwma_free_find.sv
// ---------------------------------------------------------------------------
// fwma_free_find
// Priority encoder: lowest handle whose live bit is clear.
// ---------------------------------------------------------------------------
module fwma_free_find
   import fwma_pkg::*;
(
   input  logic [DEPTH-1:0] live,
   output free_type         free
);

   // scan from the top so the lowest free handle wins
   always_comb begin
      free = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!live[i]) begin
            free.found  = 1'b1;
            free.handle = IDX_W'(i);
         end
      end
   end

endmodule

FILE: rtl/fifo_with_move_ahead_unit.sv
// ---------------------------------------------------------------------------
// fifo_with_move_ahead_unit
// Ordered queue with handles, pop from head and move-ahead of an entry.
// ---------------------------------------------------------------------------
// channel  dir  ports                        beat
// req      in   req_valid/req_ready/req_data  one operation
// rsp      out  rsp_valid/rsp_ready/rsp_data  one result per operation
//
// Push, and an error found when the request is taken, go straight to the result register.
// Pop reads the order memory, then the value memory. Query scans the order memory from the head.
// Jump: the query scan, then one order-memory read and write per place moved, then the placement write.
// Reset clears live bits and counters; memories need no clearing.
// A stalled result holds in the output register while the next beat is taken.
// ---------------------------------------------------------------------------
`include "fifo_with_move_ahead_unit_defines.svh"

module fifo_with_move_ahead_unit
   import fwma_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_POP_ORD, ST_POP_VAL, ST_SCAN_RD, ST_SCAN_CMP,
      ST_SHIFT_RD, ST_SHIFT_WR, ST_PLACE, ST_RESP
   } state_type;

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   rsp_type              res_ff, res_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DEPTH-1:0]     live_ff, live_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;

   // order memory: handle per position, circular from head_ff
   logic [IDX_W-1:0]       order_mem [DEPTH];
   logic [IDX_W-1:0]       order_rdata_ff;
   logic                   ord_we;
   logic [IDX_W-1:0]       ord_waddr, ord_wdata, ord_raddr;
   // value memory: value per handle
   logic [VALUE_WIDTH-1:0] value_mem [DEPTH];
   logic [VALUE_WIDTH-1:0] value_rdata_ff;
   logic                   val_we;
   logic [IDX_W-1:0]       val_waddr, val_raddr;

   free_type free;

   fwma_free_find u_free (
      .live (live_ff),
      .free (free)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // next-state and memory control
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      live_in      = live_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ord_we       = 1'b0;
      ord_waddr    = '0;
      ord_wdata    = '0;
      ord_raddr    = '0;
      val_we       = 1'b0;
      val_waddr    = '0;
      val_raddr    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in            = req_data;
               res_in            = '0;
               res_in.fill_count = count_ff;
               state_in          = ST_RESP;
               case (req_data.kind)
                  KIND_PUSH: begin
                     if (count_ff == CNT_W'(DEPTH) || !free.found) begin
                        res_in.error_code = ERR_FULL;
                     end else begin
                        val_we                = 1'b1;
                        val_waddr             = free.handle;
                        ord_we                = 1'b1;
                        ord_waddr             = head_ff + count_ff[IDX_W-1:0];
                        ord_wdata             = free.handle;
                        live_in[free.handle]  = 1'b1;
                        count_in              = count_ff + 1'b1;
                        res_in.handle_out     = free.handle;
                        res_in.fill_count     = count_ff + 1'b1;
                     end
                  end
                  KIND_POP: begin
                     if (count_ff == '0) begin
                        res_in.error_code = ERR_EMPTY;
                     end else begin
                        ord_raddr = head_ff;
                        state_in  = ST_POP_ORD;
                     end
                  end
                  default: begin
                     if (!live_ff[req_data.handle_in]) begin
                        res_in.error_code = ERR_STALE;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_SCAN_RD;
                     end
                  end
               endcase
            end
         end
         // head handle is back: fetch its value, retire it
         ST_POP_ORD: begin
            val_raddr               = order_rdata_ff;
            live_in[order_rdata_ff] = 1'b0;
            head_in                 = head_ff + 1'b1;
            count_in                = count_ff - 1'b1;
            state_in                = ST_POP_VAL;
         end
         ST_POP_VAL: begin
            res_in.value_out  = value_rdata_ff;
            res_in.fill_count = count_ff;
            state_in          = ST_RESP;
         end
         ST_SCAN_RD: begin
            ord_raddr = head_ff + idx_ff;
            state_in  = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (order_rdata_ff == req_ff.handle_in) begin
               if (req_ff.kind == KIND_QUERY) begin
                  res_in.position_out = idx_ff;
                  state_in            = ST_RESP;
               end else begin
                  if (req_ff.distance >= 8'(idx_ff)) begin
                     pos_in = '0;
                  end else begin
                     pos_in = idx_ff - req_ff.distance[IDX_W-1:0];
                  end
                  state_in = ST_SHIFT_RD;
                  if (req_ff.distance == '0 || idx_ff == '0) begin
                     res_in.position_out = idx_ff;
                     state_in            = ST_RESP;
                  end
               end
            end else if ({1'b0, idx_ff} + 1'b1 >= count_ff) begin
               res_in.error_code = ERR_STALE;
               state_in          = ST_RESP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         // move slot idx-1 up to idx
         ST_SHIFT_RD: begin
            ord_raddr = head_ff + idx_ff - 1'b1;
            state_in  = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            ord_we    = 1'b1;
            ord_waddr = head_ff + idx_ff;
            ord_wdata = order_rdata_ff;
            idx_in    = idx_ff - 1'b1;
            state_in  = (idx_ff - 1'b1 == pos_ff) ? ST_PLACE : ST_SHIFT_RD;
         end
         ST_PLACE: begin
            ord_we              = 1'b1;
            ord_waddr           = head_ff + pos_ff;
            ord_wdata           = req_ff.handle_in;
            res_in.position_out = pos_ff;
            state_in            = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         live_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         live_ff      <= live_in;
      end
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
   end

   // memories, registered read
   always_ff @(posedge clock) begin
      if (ord_we) begin
         order_mem[ord_waddr] <= ord_wdata;
      end
      order_rdata_ff <= order_mem[ord_raddr];
      if (val_we) begin
         value_mem[val_waddr] <= req_in.value_in;
      end
      value_rdata_ff <= value_mem[val_raddr];
   end

   `FWMA_ASSERT(a_count_max, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `FWMA_ASSERT(a_live_count, clock, reset, 1'b1, $countones(live_ff) == 32'(count_ff))
   `FWMA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `FWMA_ASSERT(a_scan_bound, clock, reset, state_ff == ST_SCAN_CMP, {1'b0, idx_ff} < count_ff)

endmodule
